// ===== sv/tsp_pkg.sv =====
// shared types, constants and codes of the tcp source port learner
// depends on nothing; every other file of the block imports it
package tsp_pkg;

  // table and frame sizing
  localparam int TABLE_DEPTH     = 128;
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int FIFO_DEPTH      = 4;

  // frame layout
  localparam int ETH_HDR_BYTES = 14;
  localparam int SRC_IP_FIRST  = 26;
  localparam int SRC_IP_LAST   = 29;

  // derived widths
  localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W  = ((POS_W > 7) ? POS_W : 7) + 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FPTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_MATCH_SOURCE_IP  = 2'd0;
  localparam logic [1:0] CFG_PORT_LOWER_BOUND = 2'd1;
  localparam logic [1:0] CFG_PORT_UPPER_BOUND = 2'd2;

  // configuration reset values
  localparam logic [31:0] RST_MATCH_SOURCE_IP  = 32'h7F00_0001;
  localparam logic [15:0] RST_PORT_LOWER_BOUND = 16'd8000;
  localparam logic [15:0] RST_PORT_UPPER_BOUND = 16'd8999;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        new_port;
    logic [15:0] learned_port;
    logic        table_full;
    logic        frame_short;
  } out_item_t;

  typedef struct packed {
    logic [31:0] match_source_ip;
    logic [15:0] port_lower_bound;
    logic [15:0] port_upper_bound;
  } cfg_t;

  // one classified frame, queued between parser and table
  typedef struct packed {
    logic [15:0] port;
    logic        frame_short;
    logic        lookup;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic valid;
  } fifo_status_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic             busy;
  } tbl_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } tbl_state_e;

endpackage

// ===== sv/tcp_source_port_learner.sv =====
// top level of the tcp source port learner: configuration registers,
// parser, frame queue and port table search; uses tsp_pkg and all tsp_ modules
//
// Frame bytes enter one per cycle on the input channel; in_stall_o rises
// only while the four-deep frame queue is full. Each frame's last byte
// yields exactly one result beat. A frame whose source address and port
// pass the configured filter is searched in the learned table, one stored
// entry at a time (registered table read, then compare), until a hit or
// the fill count of the 128-entry table is reached. Short, rejected and
// unchecked frames skip the search. Frames shorter than the search time
// back up in the queue and then stall the input. The table needs no
// clearing pass; only entries below the fill count are ever read.
module tcp_source_port_learner (
  input  logic               clk_i,
  input  logic               rst_ni,
  // frame byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsp_pkg::in_item_t  in_item_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsp_pkg::out_item_t out_item_o,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);
  import tsp_pkg::*;

  cfg_t         cfg_q;
  logic         in_accept;
  logic         push;
  logic         pop;
  frame_rec_t   rec_in;
  frame_rec_t   rec_out;
  fifo_status_t fifo_st;
  tbl_status_t  tbl_st;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_source_ip  <= RST_MATCH_SOURCE_IP;
      cfg_q.port_lower_bound <= RST_PORT_LOWER_BOUND;
      cfg_q.port_upper_bound <= RST_PORT_UPPER_BOUND;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MATCH_SOURCE_IP:  cfg_q.match_source_ip  <= cfg_wdata_i;
        CFG_PORT_LOWER_BOUND: cfg_q.port_lower_bound <= cfg_wdata_i[15:0];
        CFG_PORT_UPPER_BOUND: cfg_q.port_upper_bound <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // input side stalls only on a full frame queue
  assign in_stall_o = fifo_st.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  tsp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .push_o    (push),
    .rec_o     (rec_in)
  );

  tsp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .rec_i    (rec_in),
    .pop_i    (pop),
    .rec_o    (rec_out),
    .status_o (fifo_st)
  );

  tsp_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (fifo_st.valid),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .status_o    (tbl_st)
  );

  // a frame never lands in a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_st.full)
    else $error("frame pushed into full queue");

  // the fill count only moves together with a new-port beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_st.entry_count != $past(tbl_st.entry_count))
      |-> (out_valid_o && out_item_o.new_port
           && (tbl_st.entry_count == $past(tbl_st.entry_count) + CNT_W'(1))))
    else $error("entry count changed without a new port");

  // fill count stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_st.entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // a short frame carries no port and no table outcome
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.frame_short)
      |-> (out_item_o.learned_port == 16'd0 && !out_item_o.new_port
           && !out_item_o.table_full))
    else $error("short frame with port outcome");

endmodule

// ===== sv/tsp_parser.sv =====
// front end: walks frame bytes, captures source address and tcp port,
// classifies the frame on its last byte; uses tsp_pkg
module tsp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  tsp_pkg::in_item_t   in_item_i,
  input  tsp_pkg::cfg_t       cfg_i,
  output logic                push_o,
  output tsp_pkg::frame_rec_t rec_o
);
  import tsp_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [5:0]       ihl_q, ihl_d;
  logic [31:0]      ip_q, ip_d;
  logic [15:0]      port_q, port_d;

  logic             pos_lt_max;
  logic [5:0]       ihl_cur;
  logic [CMP_W-1:0] port_hi;
  logic [CMP_W-1:0] pos_x;
  logic [31:0]      ip_nx;
  logic [15:0]      port_nx;
  logic [7:0]       b;
  logic             is_short;
  logic             is_last;

  always_comb begin
    b          = in_item_i.frame_byte;
    pos_lt_max = (pos_q < POS_W'(MAX_FRAME_BYTES));
    pos_x      = CMP_W'(pos_q);
    ihl_cur    = (pos_lt_max && (pos_q == POS_W'(ETH_HDR_BYTES)))
                 ? {b[3:0], 2'b00} : ihl_q;
    port_hi    = CMP_W'(ETH_HDR_BYTES) + CMP_W'(ihl_cur);
    ip_nx      = ip_q;
    port_nx    = port_q;
    pos_d      = pos_q;
    ihl_d      = ihl_q;
    if (pos_lt_max) begin
      ihl_d = ihl_cur;
      if ((pos_x >= CMP_W'(SRC_IP_FIRST)) && (pos_x <= CMP_W'(SRC_IP_LAST))) begin
        ip_nx = {ip_q[23:0], b};
      end
      if ((pos_x >= CMP_W'(ETH_HDR_BYTES)) && (pos_x == port_hi)) begin
        port_nx = {b, port_nx[7:0]};
      end
      if ((pos_x >= CMP_W'(ETH_HDR_BYTES)) && (pos_x == port_hi + CMP_W'(1))) begin
        port_nx = {port_nx[15:8], b};
      end
      pos_d = pos_q + POS_W'(1);
    end
    // port high byte at or after this byte, or address not complete
    is_short = (pos_x <= port_hi) || (pos_x < CMP_W'(SRC_IP_LAST));
    is_last  = in_item_i.last_byte;

    rec_o.frame_short = is_short;
    rec_o.port        = is_short ? 16'd0 : port_nx;
    rec_o.lookup      = !is_short && (ip_nx == cfg_i.match_source_ip)
                        && (port_nx > cfg_i.port_lower_bound)
                        && (port_nx < cfg_i.port_upper_bound);
    push_o            = accept_i && is_last;

    ip_d   = ip_nx;
    port_d = port_nx;
    if (is_last) begin
      pos_d  = '0;
      ihl_d  = '0;
      ip_d   = '0;
      port_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      ihl_q  <= '0;
      ip_q   <= '0;
      port_q <= '0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      ihl_q  <= ihl_d;
      ip_q   <= ip_d;
      port_q <= port_d;
    end
  end

endmodule

// ===== sv/tsp_fifo.sv =====
// short queue of classified frames between parser and table search
// uses tsp_pkg
module tsp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tsp_pkg::frame_rec_t   rec_i,
  input  logic                  pop_i,
  output tsp_pkg::frame_rec_t   rec_o,
  output tsp_pkg::fifo_status_t status_o
);
  import tsp_pkg::*;

  frame_rec_t        slots_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] count_q;

  function automatic logic [FPTR_W-1:0] ptr_next(input logic [FPTR_W-1:0] p);
    ptr_next = (p == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FPTR_W'(1);
  endfunction

  assign rec_o          = slots_q[rd_ptr_q];
  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == FCNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FCNT_W'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - FCNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/tsp_table.sv =====
// back end: searches the learned port table entry by entry (read, then compare),
// appends unseen ports and holds the result beat; uses tsp_pkg
module tsp_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rec_valid_i,
  input  tsp_pkg::frame_rec_t  rec_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tsp_pkg::out_item_t   out_item_o,
  output tsp_pkg::tbl_status_t status_o
);
  import tsp_pkg::*;

  logic [15:0] mem [TABLE_DEPTH];

  tbl_state_e       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      port_q, port_d;
  logic [15:0]      rd_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic out_free;
  logic start;
  logic at_end;
  logic has_room;
  logic hit;
  logic rd_en;
  logic wr_en;
  logic load;

  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    start    = rec_valid_i && out_free;
    at_end   = (idx_q == count_q);
    has_room = (count_q < CNT_W'(TABLE_DEPTH));
    hit      = (rd_q == port_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && rec_i.lookup) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = at_end ? ST_IDLE : ST_CMP;
      end
      ST_CMP: begin
        state_d = hit ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    load    = 1'b0;
    idx_d   = idx_q;
    count_d = count_q;
    port_d  = port_q;
    out_d   = out_q;
    unique case (state_q)
      ST_IDLE: begin
        pop_o = start;
        if (start) begin
          if (rec_i.lookup) begin
            port_d = rec_i.port;
            idx_d  = '0;
          end else begin
            load              = 1'b1;
            out_d.new_port     = 1'b0;
            out_d.learned_port = rec_i.port;
            out_d.table_full   = 1'b0;
            out_d.frame_short  = rec_i.frame_short;
          end
        end
      end
      ST_READ: begin
        if (at_end) begin
          // port not seen: append or report a full table
          load               = 1'b1;
          wr_en              = has_room;
          out_d.new_port     = has_room;
          out_d.learned_port = port_q;
          out_d.table_full   = !has_room;
          out_d.frame_short  = 1'b0;
          if (has_room) begin
            count_d = count_q + CNT_W'(1);
          end
        end else begin
          rd_en = 1'b1;
        end
      end
      ST_CMP: begin
        if (hit) begin
          load               = 1'b1;
          out_d.new_port     = 1'b0;
          out_d.learned_port = port_q;
          out_d.table_full   = 1'b0;
          out_d.frame_short  = 1'b0;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[idx_q[ADDR_W-1:0]];
    end
    if (wr_en) begin
      mem[count_q[ADDR_W-1:0]] <= port_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    port_q <= port_d;
    out_q  <= out_d;
  end

  assign out_valid_o          = out_valid_q;
  assign out_item_o           = out_q;
  assign status_o.entry_count = count_q;
  assign status_o.busy        = (state_q != ST_IDLE);

endmodule

// ===== verif/tcp_source_port_learner_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of tcp_source_port_learner: frame byte driver,
// result scoreboard and a beat-level port learning predictor; needs tsp_pkg and the rtl
module tcp_source_port_learner_tb;
  import tsp_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 4;
  // worst table search runs over a full 128-entry table, settle well past it
  localparam int SETTLE_CYCLES = 300;
  // long receiver hold-off, enough to back up the frame queue and stall input
  localparam int HOLD_CYCLES   = 1500;
  // cycles with no beat accepted on either side before giving up
  localparam int IDLE_LIMIT    = 12000;
  localparam int POOL_SIZE     = 12;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_e;

  // ways of filling a frame
  typedef enum logic [1:0] {
    SHAPE_IP,
    SHAPE_NOISE,
    SHAPE_ZEROS,
    SHAPE_ONES
  } frame_shape_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_MATCH_SOURCE_IP;
  logic [31:0] cfg_wdata = '0;

  tcp_source_port_learner uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor copy of the filter registers
  logic [31:0] filter_ip = RST_MATCH_SOURCE_IP;
  logic [15:0] filter_lo = RST_PORT_LOWER_BOUND;
  logic [15:0] filter_hi = RST_PORT_UPPER_BOUND;

  // predictor copy of the per-frame parse state, position holds up to the cap
  logic [11:0] frame_pos  = '0;
  logic [5:0]  ihl_bytes  = '0;
  logic [31:0] frame_src  = '0;
  logic [15:0] frame_port = '0;

  // predictor copy of the learned port table
  logic [15:0] learned_ports [TABLE_DEPTH];
  logic [7:0]  learned_count = '0;

  in_item_t  pending_beats [$];     // beats waiting for the driver
  out_item_t expected_results [$];  // one verdict per finished frame
  logic [15:0] port_pool [POOL_SIZE];

  int unsigned beats_offered  = 0;
  int unsigned beats_taken    = 0;
  int unsigned beats_queued   = 0;
  int unsigned frames_queued  = 0;
  int unsigned results_seen   = 0;
  int unsigned predicted_new  = 0;
  int unsigned predicted_full = 0;
  int unsigned short_frames   = 0;
  int unsigned failures       = 0;
  int unsigned idle_cycles    = 0;

  // driver burst and gap bookkeeping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // receiver pattern bookkeeping
  rx_mode_e    rx_mode      = RX_OPEN;
  int unsigned rx_seg_left  = 0;
  int unsigned hold_left    = 0;
  bit          hold_armed   = 1'b0;
  bit          hold_used    = 1'b0;
  logic        stall_next;

  out_item_t   want;
  logic [15:0] low_bound;

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // follows one accepted beat through the parse; on the last byte works out
  // the verdict, updates the learned table and queues the expected result
  task automatic track_beat(input in_item_t beat);
    int unsigned here;
    int unsigned port_at;
    int unsigned slot;
    out_item_t   verdict;
    bit          known;
    here    = frame_pos;
    port_at = ETH_HDR_BYTES + ihl_bytes;
    if (here < MAX_FRAME_BYTES) begin
      // ihl nibble sets where the port sits, can land on this very byte
      if (here == ETH_HDR_BYTES) begin
        ihl_bytes = {beat.frame_byte[3:0], 2'b00};
        port_at   = ETH_HDR_BYTES + {beat.frame_byte[3:0], 2'b00};
      end
      if (here >= SRC_IP_FIRST && here <= SRC_IP_LAST) begin
        frame_src = {frame_src[23:0], beat.frame_byte};
      end
      if (here >= ETH_HDR_BYTES && here == port_at) begin
        frame_port[15:8] = beat.frame_byte;
      end
      if (here >= ETH_HDR_BYTES && here == port_at + 1) begin
        frame_port[7:0] = beat.frame_byte;
      end
      frame_pos = 12'(here + 1);
    end
    if (beat.last_byte) begin
      verdict = '0;
      if (here < ETH_HDR_BYTES || here < port_at + 1 || here < SRC_IP_LAST) begin
        // ended before the port or the source address was complete
        verdict.frame_short = 1'b1;
        short_frames++;
      end else begin
        verdict.learned_port = frame_port;
        if (frame_src == filter_ip && frame_port > filter_lo && frame_port < filter_hi) begin
          known = 1'b0;
          for (slot = 0; slot < learned_count; slot++) begin
            if (learned_ports[slot] == frame_port) known = 1'b1;
          end
          if (!known) begin
            if (learned_count < TABLE_DEPTH) begin
              learned_ports[learned_count] = frame_port;
              learned_count++;
              verdict.new_port = 1'b1;
              predicted_new++;
            end else begin
              // unseen port but no room left
              verdict.table_full = 1'b1;
              predicted_full++;
            end
          end
        end
      end
      expected_results.push_back(verdict);
      frame_pos  = '0;
      ihl_bytes  = '0;
      frame_src  = '0;
      frame_port = '0;
    end
  endtask

  // queues one frame of len bytes; in ip shape the source address, the ihl
  // nibble and the port are placed, the rest of the bytes are random
  task automatic build_frame(input frame_shape_e shape, input int len, input logic [3:0] ihl,
                             input logic [31:0] src, input logic [15:0] port);
    int       idx;
    int       port_at;
    logic [7:0] b;
    in_item_t beat;
    port_at = ETH_HDR_BYTES + 4 * ihl;
    for (idx = 0; idx < len; idx++) begin
      case (shape)
        SHAPE_ZEROS: b = 8'h00;
        SHAPE_ONES:  b = 8'hFF;
        SHAPE_NOISE: b = 8'($urandom_range(0, 255));
        default: begin
          b = 8'($urandom_range(0, 255));
          if (idx >= SRC_IP_FIRST && idx <= SRC_IP_LAST) b = src[8 * (SRC_IP_LAST - idx) +: 8];
          if (idx == port_at) b = port[15:8];
          if (idx == port_at + 1) b = port[7:0];
          // with ihl 0 the port high byte shares the ihl byte
          if (idx == ETH_HDR_BYTES) b = {(idx == port_at) ? port[15:12] : 4'h4, ihl};
        end
      endcase
      beat.frame_byte = b;
      beat.last_byte  = (idx == len - 1);
      pending_beats.push_back(beat);
    end
    beats_queued += len;
    frames_queued++;
  endtask

  // one random frame, mostly well formed and aimed at the current filter
  task automatic random_frame();
    int          pick;
    int          need;
    logic [3:0]  ihl;
    logic [31:0] src;
    logic [15:0] port;
    if ($urandom_range(0, 9) < 7) ihl = 4'd5;
    else ihl = 4'($urandom_range(0, 15));
    need = ETH_HDR_BYTES + 4 * ihl + 2;
    if (need < SRC_IP_LAST + 1) need = SRC_IP_LAST + 1;
    if ($urandom_range(0, 9) < 8) src = filter_ip;
    else src = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (pick < 7) begin
      // bounds and their neighbors
      case ($urandom_range(0, 3))
        0:       port = filter_lo;
        1:       port = filter_lo + 16'd1;
        2:       port = filter_hi - 16'd1;
        default: port = filter_hi;
      endcase
    end else begin
      port = 16'($urandom_range(0, 65535));
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) build_frame(SHAPE_NOISE, $urandom_range(1, 80), ihl, src, port);
    else if (pick < 20) build_frame(SHAPE_IP, $urandom_range(1, need - 1), ihl, src, port);
    else build_frame(SHAPE_IP, need + $urandom_range(0, 14), ihl, src, port);
  endtask

  task automatic random_beats(input int unsigned count);
    int unsigned target;
    target = beats_queued + count;
    while (beats_queued < target) random_frame();
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_MATCH_SOURCE_IP:  filter_ip = value;
      CFG_PORT_LOWER_BOUND: filter_lo = value[15:0];
      CFG_PORT_UPPER_BOUND: filter_hi = value[15:0];
      default: ;
    endcase
  endtask

  // writes all three filter registers and draws a fresh pool of ports
  task automatic set_filter(input logic [31:0] ip, input logic [15:0] lo, input logic [15:0] hi);
    int idx;
    write_reg(CFG_MATCH_SOURCE_IP, ip);
    write_reg(CFG_PORT_LOWER_BOUND, {16'd0, lo});
    write_reg(CFG_PORT_UPPER_BOUND, {16'd0, hi});
    for (idx = 0; idx < POOL_SIZE; idx++) begin
      if (filter_hi > filter_lo + 1) begin
        port_pool[idx] = 16'(filter_lo + 16'd1 + $urandom_range(0, filter_hi - filter_lo - 2));
      end else begin
        port_pool[idx] = 16'($urandom_range(0, 65535));
      end
    end
  endtask

  // waits until every beat is in and every result is out, then lets the
  // table search of a last frame run out before anything else happens
  task automatic drain();
    while (pending_beats.size() != 0 || beats_offered != beats_taken ||
           expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length, each after a random gap, some with none
  always @(negedge clk) begin
    if (rst_n && beats_offered == beats_taken) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        in_item  <= pending_beats.pop_front();
        in_valid <= 1'b1;
        beats_offered++;
        burst_left--;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern in segments, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_armed && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      if (rx_seg_left == 0) begin
        rx_mode     = rx_mode_e'($urandom_range(0, 3));
        rx_seg_left = $urandom_range(20, 200);
      end
      rx_seg_left--;
      case (rx_mode)
        RX_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
        RX_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
        RX_TOGGLE: stall_next = ~out_stall;
        default:   stall_next = 1'b0;
      endcase
    end
    out_stall <= stall_next;
  end

  // scoreboard: result beats are checked before the input beat of the same
  // edge is tracked, so the oldest expectation is always the one compared
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected, learned_port %0d", out_item.learned_port);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.new_port !== want.new_port) begin
            $error("new_port: expected %0b, got %0b", want.new_port, out_item.new_port);
            failures++;
          end
          if (out_item.learned_port !== want.learned_port) begin
            $error("learned_port: expected %0d, got %0d", want.learned_port,
                   out_item.learned_port);
            failures++;
          end
          if (out_item.table_full !== want.table_full) begin
            $error("table_full: expected %0b, got %0b", want.table_full, out_item.table_full);
            failures++;
          end
          if (out_item.frame_short !== want.frame_short) begin
            $error("frame_short: expected %0b, got %0b", want.frame_short, out_item.frame_short);
            failures++;
          end
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        track_beat(in_item);
        beats_taken++;
      end
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames under the reset filter
    set_filter(RST_MATCH_SOURCE_IP, RST_PORT_LOWER_BOUND, RST_PORT_UPPER_BOUND);
    build_frame(SHAPE_IP, 1, 4'd5, filter_ip, 16'd8001);    // lone last byte
    build_frame(SHAPE_IP, 14, 4'd5, filter_ip, 16'd8001);   // inside ethernet header
    build_frame(SHAPE_IP, 29, 4'd0, filter_ip, 16'h2010);   // port there, address cut
    build_frame(SHAPE_IP, 35, 4'd5, filter_ip, 16'd8001);   // port low byte missing
    build_frame(SHAPE_IP, 36, 4'd5, filter_ip, 16'd8001);   // shortest full frame, new
    build_frame(SHAPE_IP, 50, 4'd5, filter_ip, 16'd8001);   // same port again, known
    build_frame(SHAPE_IP, 36, 4'd5, filter_ip, 16'd8000);   // on the lower bound
    build_frame(SHAPE_IP, 36, 4'd5, filter_ip, 16'd8999);   // on the upper bound
    build_frame(SHAPE_IP, 40, 4'd5, filter_ip, 16'd8998);   // just inside, new
    build_frame(SHAPE_IP, 40, 4'd5, filter_ip + 32'd1, 16'd8002);  // address mismatch
    build_frame(SHAPE_IP, 30, 4'd0, filter_ip, 16'h2010);   // ihl 0, port on ihl byte
    build_frame(SHAPE_IP, 40, 4'd3, filter_ip, 16'd8003);   // port overlaps address
    build_frame(SHAPE_IP, 76, 4'd15, filter_ip, 16'd8500);  // largest ip header
    build_frame(SHAPE_ZEROS, 40, 4'd0, '0, '0);
    build_frame(SHAPE_ONES, 40, 4'd0, '0, '0);
    drain();

    // widest filter, all-ones address
    set_filter(32'hFFFF_FFFF, 16'd0, 16'hFFFF);
    random_beats(400);
    drain();

    // empty port window, all-zero address
    set_filter(32'h0000_0000, 16'hFFFF, 16'h0000);
    random_beats(200);
    drain();

    // random address and window; receiver holds off so the queue backs up
    low_bound = 16'($urandom_range(0, 60000));
    set_filter($urandom, low_bound, low_bound + 16'($urandom_range(2, 5000)));
    hold_armed = 1'b1;
    random_beats(550);
    drain();

    // random address with the full port window
    set_filter($urandom, 16'd0, 16'hFFFF);
    random_beats(100);
    drain();

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures += expected_results.size();
    end
    $display("covered %0d beats in %0d frames under 5 filter settings, %0d results checked",
             beats_taken, frames_queued, results_seen);
    $display("%0d ports learned, %0d dropped on a full table, %0d short frames",
             predicted_new, predicted_full, short_frames);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
